// ===== design/u8d_pkg.sv =====
// u8d_pkg: shared widths, byte codes, types and helpers for the utf-8 decoder
// no dependencies; used by the interfaces, the decode and tally parts and the top level
package u8d_pkg;

    localparam int BYTE_W  = 8;
    localparam int CP_W    = 21;
    localparam int USED_W  = 3;
    localparam int TOTAL_W = 32;
    localparam int CNT_W   = 2;

    localparam logic [CP_W-1:0]   MAX_CODE   = 21'h10FFFF;
    localparam logic [CP_W-1:0]   REPL_RESET = 21'd63;

    localparam logic [BYTE_W-1:0] ASCII_MAX  = 8'h7F;
    localparam logic [BYTE_W-1:0] LEAD_MIN   = 8'hC0;
    localparam logic [BYTE_W-1:0] LEAD_MAX   = 8'hF4;
    localparam logic [BYTE_W-1:0] LEAD_C2    = 8'hC2;
    localparam logic [BYTE_W-1:0] LEAD_E0    = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD_ED    = 8'hED;
    localparam logic [BYTE_W-1:0] LEAD_F0    = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD_F4    = 8'hF4;
    localparam logic [BYTE_W-1:0] SEC_8F     = 8'h8F;
    localparam logic [BYTE_W-1:0] SEC_90     = 8'h90;
    localparam logic [BYTE_W-1:0] SEC_9F     = 8'h9F;

    localparam logic [USED_W-1:0] USED_1 = 3'd1;
    localparam logic [USED_W-1:0] USED_2 = 3'd2;
    localparam logic [USED_W-1:0] USED_3 = 3'd3;
    localparam logic [USED_W-1:0] USED_4 = 3'd4;

    // results caused by one byte; any after the first are single-byte errors
    typedef struct packed {
        logic [CNT_W-1:0]  n;
        logic [CP_W-1:0]   cp;
        logic [USED_W-1:0] used;
        logic              valid;
    } t_burst;

    typedef struct packed {
        logic [TOTAL_W-1:0] rune;
        logic [TOTAL_W-1:0] valid_rune;
        logic [TOTAL_W-1:0] invalid_byte;
    } t_totals;

    function automatic logic is_tail(input logic [BYTE_W-1:0] b);
        return b[7:6] == 2'b10;
    endfunction

endpackage

// ===== design/u8d_byte_if.sv =====
// u8d_byte_if: byte channel into the decoder, valid/ready with byte and end-of-text flag
// depends on u8d_pkg
interface u8d_byte_if;
    import u8d_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] byte_in;
    logic              text_last;

    modport source (output valid, output byte_in, output text_last, input ready);
    modport sink   (input valid, input byte_in, input text_last, output ready);
endinterface

// ===== design/u8d_rune_if.sv =====
// u8d_rune_if: rune channel out of the decoder, valid/ready with rune and running totals
// depends on u8d_pkg
interface u8d_rune_if;
    import u8d_pkg::*;

    logic               valid;
    logic               ready;
    logic [CP_W-1:0]    code_point;
    logic [USED_W-1:0]  bytes_used;
    logic               rune_valid;
    logic               run_end;
    logic               text_end;
    logic [TOTAL_W-1:0] rune_total;
    logic [TOTAL_W-1:0] valid_rune_total;
    logic [TOTAL_W-1:0] invalid_byte_total;

    modport source (
        output valid, output code_point, output bytes_used, output rune_valid,
        output run_end, output text_end, output rune_total, output valid_rune_total,
        output invalid_byte_total, input ready
    );
    modport sink (
        input valid, input code_point, input bytes_used, input rune_valid,
        input run_end, input text_end, input rune_total, input valid_rune_total,
        input invalid_byte_total, output ready
    );
endinterface

// ===== design/u8d_decode.sv =====
// u8d_decode: holds the pending sequence bytes and decodes one byte into a burst of runes
// depends on u8d_pkg
module u8d_decode (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_commit,
    input  logic [u8d_pkg::BYTE_W-1:0] i_byte,
    input  logic                       i_last,
    output u8d_pkg::t_burst            o_burst
);
    import u8d_pkg::*;

    logic [BYTE_W-1:0] r_lead, r_second, r_third;
    logic [1:0]        r_held;
    logic [BYTE_W-1:0] n_lead, n_second, n_third;
    logic [1:0]        n_held;
    logic [CP_W-1:0]   cp4;
    logic              tail;

    always_comb begin
        cp4 = {r_lead[2:0], r_second[5:0], r_third[5:0], i_byte[5:0]};
        tail = is_tail(i_byte);
        o_burst = '{n: 2'd0, cp: '0, used: USED_1, valid: 1'b0};
        n_lead = r_lead;
        n_second = r_second;
        n_third = r_third;
        n_held = 2'd0;
        case (r_held)
            2'd0: begin
                if (i_byte <= ASCII_MAX) begin
                    o_burst = '{n: 2'd1, cp: CP_W'(i_byte), used: USED_1, valid: 1'b1};
                end else if (i_byte inside {[LEAD_MIN:LEAD_MAX]} && !i_last) begin
                    n_lead = i_byte;
                    n_held = 2'd1;
                end else begin
                    o_burst.n = 2'd1;
                end
            end
            2'd1: begin
                if (r_lead[7:5] == 3'b110) begin
                    if (!tail) begin
                        o_burst = '{n: 2'd1, cp: '0, used: USED_2, valid: 1'b0};
                    end else if (r_lead >= LEAD_C2) begin
                        o_burst = '{n: 2'd1, cp: {10'd0, r_lead[4:0], i_byte[5:0]},
                                    used: USED_2, valid: 1'b1};
                    end else begin
                        o_burst.n = 2'd2;
                    end
                end else if (!tail || i_last) begin
                    o_burst = '{n: 2'd1, cp: '0, used: USED_2, valid: 1'b0};
                end else begin
                    n_second = i_byte;
                    n_held = 2'd2;
                end
            end
            2'd2: begin
                if (r_lead[7:4] == 4'hE) begin
                    if (!tail) begin
                        o_burst = '{n: 2'd1, cp: '0, used: USED_3, valid: 1'b0};
                    end else if ((r_lead == LEAD_E0 && r_second <= SEC_9F) ||
                                 (r_lead == LEAD_ED && r_second > SEC_9F)) begin
                        o_burst = '{n: 2'd2, cp: '0, used: USED_2, valid: 1'b0};
                    end else begin
                        o_burst = '{n: 2'd1,
                                    cp: {5'd0, r_lead[3:0], r_second[5:0], i_byte[5:0]},
                                    used: USED_3, valid: 1'b1};
                    end
                end else if (!tail || i_last) begin
                    o_burst = '{n: 2'd1, cp: '0, used: USED_3, valid: 1'b0};
                end else begin
                    n_third = i_byte;
                    n_held = 2'd3;
                end
            end
            default: begin
                if (!tail) begin
                    o_burst = '{n: 2'd1, cp: '0, used: USED_4, valid: 1'b0};
                end else if ((r_lead == LEAD_F0 && r_second < SEC_90) ||
                             (r_lead == LEAD_F4 && r_second > SEC_8F)) begin
                    o_burst = '{n: 2'd3, cp: '0, used: USED_2, valid: 1'b0};
                end else begin
                    o_burst = '{n: 2'd1, cp: cp4, used: USED_4, valid: cp4 <= MAX_CODE};
                end
            end
        endcase
        if (i_last) begin
            n_held = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held   <= 2'd0;
            r_lead   <= '0;
            r_second <= '0;
            r_third  <= '0;
        end else if (i_commit) begin
            r_held   <= n_held;
            r_lead   <= n_lead;
            r_second <= n_second;
            r_third  <= n_third;
        end
    end
endmodule

// ===== design/u8d_tally.sv =====
// u8d_tally: saturating running totals of runes, valid runes and error bytes per text
// depends on u8d_pkg
module u8d_tally (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_step,
    input  logic                       i_valid,
    input  logic [u8d_pkg::USED_W-1:0] i_used,
    input  logic                       i_clear,
    output u8d_pkg::t_totals           o_totals
);
    import u8d_pkg::*;

    t_totals r_tot;

    function automatic logic [TOTAL_W-1:0] sat_add(input logic [TOTAL_W-1:0] a,
                                                   input logic [USED_W-1:0] b);
        logic [TOTAL_W:0] s;
        s = {1'b0, a} + (TOTAL_W + 1)'(b);
        return s[TOTAL_W] ? {TOTAL_W{1'b1}} : s[TOTAL_W-1:0];
    endfunction

    always_comb begin
        o_totals.rune         = sat_add(r_tot.rune, USED_1);
        o_totals.valid_rune   = i_valid ? sat_add(r_tot.valid_rune, USED_1) : r_tot.valid_rune;
        o_totals.invalid_byte = i_valid ? r_tot.invalid_byte : sat_add(r_tot.invalid_byte, i_used);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tot <= '0;
        end else if (i_step) begin
            r_tot <= i_clear ? '0 : o_totals;
        end
    end
endmodule

// ===== design/utf8_validating_decoder.sv =====
// utf8_validating_decoder: streaming utf-8 decoder with error runes and per-text totals.
// Takes one byte per transfer; a byte register feeds the decoder, a burst register holds
// the runes one byte causes, and an output register parts the rune channel from the rest.
// Bytes are accepted every cycle while each causes at most one rune and the rune channel
// does not stall; a byte causing two or three error runes holds the burst register until
// all are popped, one rune a cycle unless stalled. Totals clear after the text_end rune.
// The user must write the replacement code only while idle; the block does not check it.
// depends on u8d_pkg, u8d_byte_if, u8d_rune_if, u8d_decode, u8d_tally
module utf8_validating_decoder (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    u8d_byte_if.sink                 i_byte,
    u8d_rune_if.source               o_rune,
    input  logic                     i_cfg_we,
    input  logic [u8d_pkg::CP_W-1:0] i_cfg_wdata
);
    import u8d_pkg::*;

    logic [CP_W-1:0]   r_repl;

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_last;

    logic [CNT_W-1:0]  r_b_rem;
    logic              r_b_head;
    logic              r_b_last;
    logic [CP_W-1:0]   r_b_cp;
    logic [USED_W-1:0] r_b_used;
    logic              r_b_valid;

    logic               r_o_valid;
    logic [CP_W-1:0]    r_o_cp;
    logic [USED_W-1:0]  r_o_used;
    logic               r_o_rvalid;
    logic               r_o_run_end;
    logic               r_o_text_end;
    t_totals            r_o_tot;

    t_burst            burst;
    t_totals           totals;
    logic              pop, bst_free, in_take;
    logic              p_valid, p_run_end, p_text_end;
    logic [USED_W-1:0] p_used;
    logic [CP_W-1:0]   p_cp;

    assign pop      = (r_b_rem != '0) && (!r_o_valid || o_rune.ready);
    assign bst_free = (r_b_rem == '0) || (r_b_rem == CNT_W'(1) && pop);
    assign in_take  = r_in_valid && bst_free;
    assign i_byte.ready = !r_in_valid || in_take;

    // runes after the first of a burst are single-byte errors
    assign p_valid    = r_b_head & r_b_valid;
    assign p_used     = r_b_head ? r_b_used : USED_1;
    assign p_cp       = p_valid ? r_b_cp : r_repl;
    assign p_run_end  = r_b_rem == CNT_W'(1);
    assign p_text_end = p_run_end && r_b_last;

    u8d_decode u_decode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_commit (in_take),
        .i_byte   (r_in_byte),
        .i_last   (r_in_last),
        .o_burst  (burst)
    );

    u8d_tally u_tally (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (pop),
        .i_valid  (p_valid),
        .i_used   (p_used),
        .i_clear  (p_text_end),
        .o_totals (totals)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_repl <= REPL_RESET;
        end else if (i_cfg_we) begin
            r_repl <= i_cfg_wdata;
        end
    end

    // byte register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_byte.valid && i_byte.ready) begin
            r_in_valid <= 1'b1;
        end else if (in_take) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte.valid && i_byte.ready) begin
            r_in_byte <= i_byte.byte_in;
            r_in_last <= i_byte.text_last;
        end
    end

    // burst register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_rem  <= '0;
            r_b_head <= 1'b0;
        end else if (in_take) begin
            r_b_rem  <= burst.n;
            r_b_head <= 1'b1;
        end else if (pop) begin
            r_b_rem  <= r_b_rem - CNT_W'(1);
            r_b_head <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_b_last  <= r_in_last;
            r_b_cp    <= burst.cp;
            r_b_used  <= burst.used;
            r_b_valid <= burst.valid;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (pop) begin
            r_o_valid <= 1'b1;
        end else if (o_rune.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_o_cp       <= p_cp;
            r_o_used     <= p_used;
            r_o_rvalid   <= p_valid;
            r_o_run_end  <= p_run_end;
            r_o_text_end <= p_text_end;
            r_o_tot      <= totals;
        end
    end

    assign o_rune.valid              = r_o_valid;
    assign o_rune.code_point         = r_o_cp;
    assign o_rune.bytes_used         = r_o_used;
    assign o_rune.rune_valid         = r_o_rvalid;
    assign o_rune.run_end            = r_o_run_end;
    assign o_rune.text_end           = r_o_text_end;
    assign o_rune.rune_total         = r_o_tot.rune;
    assign o_rune.valid_rune_total   = r_o_tot.valid_rune;
    assign o_rune.invalid_byte_total = r_o_tot.invalid_byte;
endmodule

// ===== design/u8d_check.sv =====
// u8d_check: port-level assertions on the decoder's rune channel, bound to the top level
// depends on u8d_pkg and utf8_validating_decoder
module u8d_check (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_valid,
    input logic                        i_ready,
    input logic [u8d_pkg::CP_W-1:0]    i_code_point,
    input logic [u8d_pkg::USED_W-1:0]  i_bytes_used,
    input logic                        i_rune_valid,
    input logic                        i_run_end,
    input logic                        i_text_end,
    input logic [u8d_pkg::TOTAL_W-1:0] i_rune_total,
    input logic [u8d_pkg::TOTAL_W-1:0] i_invalid_byte_total
);
    import u8d_pkg::*;

    logic xfer;
    assign xfer = i_valid && i_ready;

    // stalled rune holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_code_point) && $stable(i_rune_total))
        else $error("stalled rune changed");

    a_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_text_end |-> i_run_end)
        else $error("text end without run end");

    // next rune in the same text counts one more, saturating
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        xfer && !i_text_end |=> !i_valid ||
            i_rune_total == (($past(i_rune_total) == {TOTAL_W{1'b1}}) ?
                             {TOTAL_W{1'b1}} : $past(i_rune_total) + TOTAL_W'(1)))
        else $error("rune total did not advance");

    a_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_rune_valid |-> i_invalid_byte_total >= TOTAL_W'(i_bytes_used))
        else $error("error bytes not counted");

    a_ascii: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_rune_valid && i_bytes_used == USED_1 |-> i_code_point <= CP_W'(ASCII_MAX))
        else $error("single-byte rune above ascii");
endmodule

bind utf8_validating_decoder u8d_check u_check (
    .i_clk                (i_clk),
    .i_rst_n              (i_rst_n),
    .i_valid              (o_rune.valid),
    .i_ready              (o_rune.ready),
    .i_code_point         (o_rune.code_point),
    .i_bytes_used         (o_rune.bytes_used),
    .i_rune_valid         (o_rune.rune_valid),
    .i_run_end            (o_rune.run_end),
    .i_text_end           (o_rune.text_end),
    .i_rune_total         (o_rune.rune_total),
    .i_invalid_byte_total (o_rune.invalid_byte_total)
);

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// tb: self-checking bench for utf8_validating_decoder, byte transfers in and rune transfers out
// depends on u8d_pkg, u8d_byte_if, u8d_rune_if and the decoder rtl
module tb;
    import u8d_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;
    localparam logic [7:0] TAIL_MIN = 8'h80;
    localparam logic [7:0] TAIL_MAX = 8'hBF;

    typedef struct packed {
        logic [CP_W-1:0]    cp;
        logic [USED_W-1:0]  used;
        logic               ok;
        logic               run_end;
        logic               text_end;
        logic [TOTAL_W-1:0] runes;
        logic [TOTAL_W-1:0] valid_runes;
        logic [TOTAL_W-1:0] bad_bytes;
    } rune_t;

    typedef struct packed {
        logic [7:0] value;
        logic       fin;
    } byte_item_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CP_W-1:0] cfg_wdata;

    u8d_byte_if bif();
    u8d_rune_if rif();

    utf8_validating_decoder dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_byte      (bif),
        .o_rune      (rif),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    // decoder state as predicted
    logic [CP_W-1:0]    repl_code = REPL_RESET;
    logic [7:0]         lead_q = '0;
    logic [7:0]         second_q = '0;
    logic [7:0]         third_q = '0;
    logic [1:0]         held_q = '0;
    logic [TOTAL_W-1:0] rune_cnt = '0;
    logic [TOTAL_W-1:0] valid_cnt = '0;
    logic [TOTAL_W-1:0] bad_cnt = '0;
    rune_t              burst [3];
    int                 burst_n;

    rune_t      runes_due [$];
    byte_item_t bytes_pending [$];
    logic [7:0] text_buf [$];
    int         bytes_queued = 0;
    int         bytes_taken = 0;
    int         errors = 0;
    int         cycle_count;
    logic       byte_done = 1'b0;
    rune_t      got_rune;
    rune_t      want_rune;

    int tx_idle_pct = 33;
    int rx_stall_pct = 33;
    bit rx_hold_arm = 1'b0;
    bit rx_hold_used = 1'b0;
    int rx_hold_left = 0;

    function automatic logic [TOTAL_W-1:0] sat_add(input logic [TOTAL_W-1:0] a,
                                                   input logic [TOTAL_W-1:0] b);
        return (a > ({TOTAL_W{1'b1}} - b)) ? {TOTAL_W{1'b1}} : a + b;
    endfunction

    function automatic bit tail_byte(input logic [7:0] b);
        return b[7:6] == 2'b10;
    endfunction

    function automatic string rune_str(input rune_t r);
        return $sformatf("cp=%06h used=%0d valid=%0b run_end=%0b text_end=%0b totals=%0d/%0d/%0d",
                         r.cp, r.used, r.ok, r.run_end, r.text_end,
                         r.runes, r.valid_runes, r.bad_bytes);
    endfunction

    task automatic emit_rune(input logic [CP_W-1:0] cp, input logic [USED_W-1:0] used,
                             input logic ok);
        rune_cnt = sat_add(rune_cnt, 1);
        if (ok)
            valid_cnt = sat_add(valid_cnt, 1);
        else
            bad_cnt = sat_add(bad_cnt, TOTAL_W'(used));
        burst[burst_n] = '{cp: ok ? cp : repl_code, used: used, ok: ok, run_end: 1'b0,
                           text_end: 1'b0, runes: rune_cnt, valid_runes: valid_cnt,
                           bad_bytes: bad_cnt};
        burst_n++;
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic fin);
        logic [7:0]      ld;
        logic [7:0]      s;
        logic            two;
        logic            three;
        logic [CP_W-1:0] cp;
        ld = lead_q;
        s = second_q;
        two = ld[7:5] == 3'b110;
        three = ld[7:4] == 4'b1110;
        burst_n = 0;
        case (held_q)
            2'd0: begin
                if (b <= ASCII_MAX) begin
                    emit_rune({13'd0, b}, USED_1, 1'b1);
                end else if (b[7:5] == 3'b110 || b[7:4] == 4'b1110 ||
                             (b >= LEAD_F0 && b <= LEAD_F4)) begin
                    if (fin) begin
                        emit_rune('0, USED_1, 1'b0);
                    end else begin
                        lead_q = b;
                        held_q = 2'd1;
                    end
                end else begin
                    emit_rune('0, USED_1, 1'b0);
                end
            end
            2'd1: begin
                held_q = 2'd0;
                if (two) begin
                    if (!tail_byte(b)) begin
                        emit_rune('0, USED_2, 1'b0);
                    end else if (ld >= LEAD_C2) begin
                        emit_rune({10'd0, ld[4:0], b[5:0]}, USED_2, 1'b1);
                    end else begin
                        emit_rune('0, USED_1, 1'b0);
                        emit_rune('0, USED_1, 1'b0);
                    end
                end else if (!tail_byte(b) || fin) begin
                    emit_rune('0, USED_2, 1'b0);
                end else begin
                    second_q = b;
                    held_q = 2'd2;
                end
            end
            2'd2: begin
                held_q = 2'd0;
                if (three) begin
                    if (!tail_byte(b)) begin
                        emit_rune('0, USED_3, 1'b0);
                    end else if ((ld == LEAD_E0 && s < 8'hA0) || (ld == LEAD_ED && s > SEC_9F)) begin
                        emit_rune('0, USED_2, 1'b0);
                        emit_rune('0, USED_1, 1'b0);
                    end else begin
                        emit_rune({5'd0, ld[3:0], s[5:0], b[5:0]}, USED_3, 1'b1);
                    end
                end else if (!tail_byte(b) || fin) begin
                    emit_rune('0, USED_3, 1'b0);
                end else begin
                    third_q = b;
                    held_q = 2'd3;
                end
            end
            default: begin
                held_q = 2'd0;
                if (!tail_byte(b)) begin
                    emit_rune('0, USED_4, 1'b0);
                end else if ((ld == LEAD_F0 && s < SEC_90) || (ld == LEAD_F4 && s > SEC_8F)) begin
                    emit_rune('0, USED_2, 1'b0);
                    emit_rune('0, USED_1, 1'b0);
                    emit_rune('0, USED_1, 1'b0);
                end else begin
                    cp = {ld[2:0], s[5:0], third_q[5:0], b[5:0]};
                    emit_rune(cp, USED_4, cp <= MAX_CODE);
                end
            end
        endcase
        if (burst_n > 0) begin
            burst[burst_n-1].run_end = 1'b1;
            if (fin) begin
                burst[burst_n-1].text_end = 1'b1;
                rune_cnt = '0;
                valid_cnt = '0;
                bad_cnt = '0;
                held_q = 2'd0;
            end
            for (int i = 0; i < burst_n; i++)
                runes_due.push_back(burst[i]);
        end
    endtask

    task automatic put_byte(input logic [7:0] b, input logic fin);
        bytes_pending.push_back('{value: b, fin: fin});
        bytes_queued++;
    endtask

    function automatic logic [7:0] any_tail();
        return TAIL_MIN | 8'($urandom_range(0, 63));
    endfunction

    function automatic logic [7:0] non_tail();
        logic [7:0] v;
        do
            v = 8'($urandom_range(0, 255));
        while (v[7:6] == 2'b10);
        return v;
    endfunction

    // second byte inside the legal range for this lead
    function automatic logic [7:0] second_ok(input logic [7:0] ld);
        case (ld)
            LEAD_E0: return 8'hA0 | 8'($urandom_range(0, 31));
            LEAD_ED: return TAIL_MIN | 8'($urandom_range(0, 31));
            LEAD_F0: return SEC_90 + 8'($urandom_range(0, 47));
            LEAD_F4: return TAIL_MIN | 8'($urandom_range(0, 15));
            default: return any_tail();
        endcase
    endfunction

    function automatic int seq_len(input logic [7:0] ld);
        return (ld >= LEAD_F0) ? 4 : (ld >= LEAD_E0) ? 3 : 2;
    endfunction

    task automatic add_rune_bytes(input bit closing);
        int         pick;
        int         n_tails;
        logic [7:0] ld;
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            case ($urandom_range(0, 3))
                0: text_buf.push_back(8'($urandom_range(0, 127)));
                1: begin
                    text_buf.push_back(8'($urandom_range(LEAD_C2, 8'hDF)));
                    text_buf.push_back(any_tail());
                end
                2: begin
                    ld = 8'($urandom_range(LEAD_E0, 8'hEF));
                    text_buf.push_back(ld);
                    text_buf.push_back(second_ok(ld));
                    text_buf.push_back(any_tail());
                end
                default: begin
                    ld = 8'($urandom_range(LEAD_F0, LEAD_F4));
                    text_buf.push_back(ld);
                    text_buf.push_back(second_ok(ld));
                    text_buf.push_back(any_tail());
                    text_buf.push_back(any_tail());
                end
            endcase
        end else if (pick < 75) begin
            text_buf.push_back(8'($urandom_range(0, 255)));
        end else if (pick < 82) begin
            // second byte out of range for the lead
            case ($urandom_range(0, 3))
                0: begin
                    text_buf.push_back(LEAD_E0);
                    text_buf.push_back(8'($urandom_range(TAIL_MIN, SEC_9F)));
                end
                1: begin
                    text_buf.push_back(LEAD_ED);
                    text_buf.push_back(8'($urandom_range(8'hA0, TAIL_MAX)));
                end
                2: begin
                    text_buf.push_back(LEAD_F0);
                    text_buf.push_back(8'($urandom_range(TAIL_MIN, SEC_8F)));
                    text_buf.push_back(any_tail());
                end
                default: begin
                    text_buf.push_back(LEAD_F4);
                    text_buf.push_back(8'($urandom_range(SEC_90, TAIL_MAX)));
                    text_buf.push_back(any_tail());
                end
            endcase
            text_buf.push_back(any_tail());
        end else if (pick < 87) begin
            text_buf.push_back(8'($urandom_range(LEAD_MIN, 8'hC1)));
            text_buf.push_back(any_tail());
        end else begin
            ld = 8'($urandom_range(LEAD_C2, LEAD_F4));
            n_tails = $urandom_range(0, seq_len(ld) - 2);
            text_buf.push_back(ld);
            for (int k = 0; k < n_tails; k++)
                text_buf.push_back(k == 0 ? second_ok(ld) : any_tail());
            // broken continuation, or a text cut short inside the sequence
            if (pick < 94 || !closing)
                text_buf.push_back(non_tail());
        end
    endtask

    task automatic queue_texts(input int n_items);
        int target;
        int n_runes;
        target = bytes_queued + n_items;
        while (bytes_queued < target) begin
            n_runes = $urandom_range(1, 10);
            text_buf.delete();
            for (int k = 0; k < n_runes; k++)
                add_rune_bytes(k == n_runes - 1);
            foreach (text_buf[i])
                put_byte(text_buf[i], i == text_buf.size() - 1);
        end
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (bytes_taken != bytes_queued || runes_due.size() != 0);
        repeat (8) @(negedge clk);
    endtask

    task automatic set_replacement(input logic [CP_W-1:0] v);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        repl_code = v;
    endtask

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // byte driver
    always @(negedge clk) begin
        byte_item_t it;
        if (!rst_n) begin
            bif.valid <= 1'b0;
        end else if (!bif.valid || byte_done) begin
            if (bytes_pending.size() > 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
                it = bytes_pending.pop_front();
                bif.valid <= 1'b1;
                bif.byte_in <= it.value;
                bif.text_last <= it.fin;
            end else begin
                bif.valid <= 1'b0;
            end
        end
    end

    // rune receiver with one long hold-off
    always @(negedge clk) begin
        if (rx_hold_arm && !rx_hold_used) begin
            rx_hold_left = HOLD_CYCLES;
            rx_hold_used = 1'b1;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            rif.ready <= 1'b0;
        end else begin
            rif.ready <= $urandom_range(0, 99) >= rx_stall_pct;
        end
    end

    // monitor: predicts on byte transfers, checks rune transfers
    always @(posedge clk) begin
        byte_done = rst_n && bif.valid && bif.ready;
        if (byte_done) begin
            bytes_taken++;
            decode_byte(bif.byte_in, bif.text_last);
        end
        if (rst_n && rif.valid && rif.ready) begin
            got_rune = '{cp: rif.code_point, used: rif.bytes_used, ok: rif.rune_valid,
                         run_end: rif.run_end, text_end: rif.text_end,
                         runes: rif.rune_total, valid_runes: rif.valid_rune_total,
                         bad_bytes: rif.invalid_byte_total};
            if (runes_due.size() == 0) begin
                errors++;
                $display("%0t unexpected rune: expected none, actual %s",
                         $time, rune_str(got_rune));
            end else begin
                want_rune = runes_due.pop_front();
                if (got_rune !== want_rune) begin
                    errors++;
                    $display("%0t rune mismatch: expected %s, actual %s",
                             $time, rune_str(want_rune), rune_str(got_rune));
                end
            end
        end
    end

    initial begin
        for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++)
            @(posedge clk);
        $display("tb NOT OK");
        $finish;
    end

    initial begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: field extremes, every error kind, default replacement
        put_byte(8'h00, 1'b0);
        put_byte(ASCII_MAX, 1'b0);
        put_byte(LEAD_C2, 1'b0);
        put_byte(TAIL_MIN, 1'b0);
        put_byte(8'hC1, 1'b0);
        put_byte(TAIL_MAX, 1'b0);
        put_byte(8'hFF, 1'b0);
        put_byte(LEAD_E0, 1'b0);
        put_byte(TAIL_MIN, 1'b0);
        put_byte(TAIL_MIN, 1'b0);
        put_byte(LEAD_ED, 1'b0);
        put_byte(8'hA0, 1'b0);
        put_byte(TAIL_MIN, 1'b0);
        put_byte(LEAD_F0, 1'b0);
        put_byte(TAIL_MIN, 1'b0);
        put_byte(TAIL_MIN, 1'b0);
        put_byte(TAIL_MIN, 1'b0);
        put_byte(LEAD_F4, 1'b0);
        put_byte(SEC_8F, 1'b0);
        put_byte(TAIL_MAX, 1'b0);
        put_byte(TAIL_MAX, 1'b0);
        put_byte(8'hE2, 1'b0);
        put_byte(8'h41, 1'b0);
        put_byte(8'hE2, 1'b0);
        put_byte(8'h82, 1'b1);
        put_byte(LEAD_F4, 1'b1);

        wait_idle();
        set_replacement('0);
        queue_texts(90);

        // long stretch with no idling on either side
        wait_idle();
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        set_replacement(MAX_CODE);
        queue_texts(90);

        wait_idle();
        tx_idle_pct = 33;
        rx_stall_pct = 33;
        set_replacement(CP_W'($urandom_range(1, MAX_CODE - 1)));
        queue_texts(100);
        rx_hold_arm = 1'b1;

        wait_idle();
        repeat (12) @(posedge clk);
        if (errors == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
